### rtl/core/mexp_pkg.sv
// shared widths and constants for the modular exponentiation block
package mexp_pkg;

    localparam int BASE_W = 63;
    localparam int EXP_W = 31;
    localparam int MOD_W = 31;
    localparam int EXP_BITS_DEF = 31;
    localparam int CNT_W = 6;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
    localparam logic [MOD_W-1:0] MODULUS_MIN = 31'd2;

endpackage

### rtl/core/modular_exponentiation_top.sv
// modular exponentiation top level with shared modular multiply-step unit
//
// A request (start while busy is low) carries base_value and exponent; done pulses for
// one cycle with power_result once the item finishes, and the receiver cannot stall it.
// Everything runs on one shift-add modular step unit, one multiplier bit per cycle:
// the base is first reduced bit by bit, then each exponent bit up to the highest set
// bit takes a decision step, a multiply into the accumulator when the bit is set, and
// a square; a last decision step ends the item. A zero base skips the exponent bits
// and ends right after the reduction. done is high in the first cycle with busy low.
// The modulus is sampled when a request is taken, and a modulus of 0 or 1 is used as 2.
module modular_exponentiation_top #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mexp_pkg::BASE_W-1:0]  base_value,
    input  logic [mexp_pkg::EXP_W-1:0]   exponent,
    output logic                         done,
    output logic [mexp_pkg::MOD_W-1:0]   power_result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mexp_pkg::MOD_W-1:0]   cfg_data
);
    import mexp_pkg::*;

    // exponent bits that take part
    localparam int EXP_USED = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_BIT    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SQR    = 3'd4;

    localparam logic [CNT_W-1:0] CNT_BASE = CNT_W'(BASE_W - 1);
    localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(MOD_W - 1);

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_W-1:0]    modulus_reg;
    logic [MOD_W-1:0]    m_reg, m_next;
    logic [BASE_W-1:0]   base_sh_reg, base_sh_next;
    logic [EXP_USED-1:0] exp_reg, exp_next;
    logic                zero_reg, zero_next;
    logic [MOD_W-1:0]    acc_reg, acc_next;
    logic [MOD_W-1:0]    pw_reg, pw_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic [MOD_W-1:0]    mplier_reg, mplier_next;
    logic                done_reg, done_next;
    logic [MOD_W-1:0]    result_reg, result_next;

    // shared step unit: ((2*r mod m) + addend) mod m, addend below m
    logic [MOD_W-1:0] addend;
    logic [MOD_W:0]   dbl;
    logic [MOD_W:0]   dbl_red;
    logic [MOD_W:0]   sum;
    logic [MOD_W-1:0] step_out;

    always_comb
    begin
        if (state_reg == S_REDUCE)
        begin
            addend = {{(MOD_W-1){1'b0}}, base_sh_reg[BASE_W-1]};
        end
        else
        begin
            addend = mplier_reg[MOD_W-1] ? pw_reg : '0;
        end
        dbl = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? (dbl - {1'b0, m_reg}) : dbl;
        sum = dbl_red + {1'b0, addend};
        if (sum >= {1'b0, m_reg})
        begin
            sum = sum - {1'b0, m_reg};
        end
        step_out = sum[MOD_W-1:0];
    end

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            modulus_reg <= cfg_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        m_next = m_reg;
        base_sh_next = base_sh_reg;
        exp_next = exp_reg;
        zero_next = zero_reg;
        acc_next = acc_reg;
        pw_next = pw_reg;
        r_next = r_reg;
        mplier_next = mplier_reg;
        done_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_next = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
                    base_sh_next = base_value;
                    exp_next = exponent[EXP_USED-1:0];
                    zero_next = (base_value == '0);
                    r_next = '0;
                    cnt_next = CNT_BASE;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                r_next = step_out;
                base_sh_next = {base_sh_reg[BASE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    pw_next = step_out;
                    acc_next = {{(MOD_W-1){1'b0}}, 1'b1};
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                r_next = '0;
                cnt_next = CNT_MUL;
                if (zero_reg || exp_reg == '0)
                begin
                    result_next = zero_reg ? '0 : acc_reg;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (exp_reg[0])
                begin
                    mplier_next = acc_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    mplier_next = pw_reg;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                r_next = step_out;
                mplier_next = {mplier_reg[MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next = step_out;
                    r_next = '0;
                    mplier_next = pw_reg;
                    cnt_next = CNT_MUL;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                r_next = step_out;
                mplier_next = {mplier_reg[MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    pw_next = step_out;
                    exp_next = exp_reg >> 1;
                    state_next = S_BIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        m_reg <= m_next;
        base_sh_reg <= base_sh_next;
        exp_reg <= exp_next;
        zero_reg <= zero_next;
        acc_reg <= acc_next;
        pw_reg <= pw_next;
        r_reg <= r_next;
        mplier_reg <= mplier_next;
        result_reg <= result_next;
    end

    // outputs
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign power_result = result_reg;
    assign cfg_ready = 1'b1;

endmodule

### rtl/core/mexp_checker.sv
// port-level checker for the modular exponentiation block, with its bind
module mexp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import mexp_pkg::*;

    // a taken request makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // block is idle while a result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // every finished item gives a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item ended without a result");

    // a result follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

### bench/modular_exponentiation_top_tb.sv
// self-checking testbench for the modular exponentiation block
module modular_exponentiation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int          EXP_BITS    = EXP_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 12_000_000;
    localparam int          NUM_PHASES  = 10;
    localparam int          PHASE_ITEMS = 98;

    // expected powers and the arithmetic behind them
    class power_scoreboard;
        logic [MOD_W-1:0] expected_powers[$];
        int unsigned      error_count;

        function new();
            error_count = 0;
        endfunction

        // a modulus register below 2 acts as 2
        static function longint unsigned floor_modulus(logic [MOD_W-1:0] mreg);
            return (mreg < MODULUS_MIN) ? 64'(MODULUS_MIN) : 64'(mreg);
        endfunction

        // square-and-multiply from the low exponent bit upward
        function logic [MOD_W-1:0] predict_power(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e,
                                                 logic [MOD_W-1:0] mreg);
            longint unsigned m;
            longint unsigned acc;
            longint unsigned pw;
            longint unsigned ex;
            m  = floor_modulus(mreg);
            ex = 64'(e) & ((64'd1 << EXP_BITS) - 64'd1);
            if (b == '0)
                return '0;
            acc = 64'd1 % m;
            pw  = 64'(b) % m;
            for (int i = 0; i < EXP_BITS; i++)
            begin
                if (ex[i])
                    acc = (acc * pw) % m;
                pw = (pw * pw) % m;
            end
            return MOD_W'(acc);
        endfunction

        function void note_request(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e,
                                   logic [MOD_W-1:0] mreg);
            expected_powers = {expected_powers, predict_power(b, e, mreg)};
        endfunction

        function void check_result(logic [MOD_W-1:0] actual);
            logic [MOD_W-1:0] want;
            if (expected_powers.size() == 0)
            begin
                $error("power_result: expected none, actual %0d", actual);
                error_count++;
                return;
            end
            want = expected_powers.pop_front();
            if (actual !== want)
            begin
                $error("power_result: expected %0d, actual %0d", want, actual);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction

        function void check_leftover();
            if (expected_powers.size() != 0)
            begin
                $error("power_result: expected %0d more results, actual none",
                       expected_powers.size());
                error_count++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    logic [BASE_W-1:0] base_value = '0;
    logic [EXP_W-1:0]  exponent   = '0;
    logic              done;
    logic [MOD_W-1:0]  power_result;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [MOD_W-1:0]  cfg_data   = '0;

    power_scoreboard   sb;
    logic [MOD_W-1:0]  modulus_setting = MODULUS_RESET;
    int unsigned       cycle_count     = 0;
    bit                no_idle         = 1'b0;

    modular_exponentiation_top #(
        .EXP_BITS(EXP_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .exponent     (exponent),
        .done         (done),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(power_result);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // issue one request, then optionally idle the start line for a burst
    task automatic send_request(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
        int gap;
        start      <= 1'b1;
        base_value <= b;
        exponent   <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(b, e, modulus_setting);
        gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            start      <= 1'b0;
            base_value <= BASE_W'({$urandom, $urandom});
            exponent   <= EXP_W'($urandom);
            // idle either mid-item or once the block has gone free
            if ($urandom_range(0, 1) == 1)
            begin
                while (busy)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off requests until every expected result is back
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the modulus register through its channel
    task automatic write_modulus(input logic [MOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        modulus_setting = value;
        cfg_valid <= 1'b0;
    endtask

    // base mix: zero, multiples of the modulus, near the modulus, small, full width
    function automatic logic [BASE_W-1:0] pick_base();
        longint unsigned m;
        longint unsigned k;
        m = power_scoreboard::floor_modulus(modulus_setting);
        case ($urandom_range(0, 9))
            0: return '0;
            1:
            begin
                k = $urandom_range(1, 32'hFFFF_FFFF);
                return BASE_W'(k * m);
            end
            2: return BASE_W'(m - 64'd1 + 64'($urandom_range(0, 2)));
            3: return BASE_W'(1);
            4, 5: return BASE_W'($urandom_range(1, 1000));
            default: return BASE_W'({$urandom, $urandom});
        endcase
    endfunction

    // mostly short exponents so items stay fast, a few at full width
    function automatic logic [EXP_W-1:0] pick_exponent();
        int w;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2, 3, 4: return EXP_W'($urandom);
            default:
            begin
                w = $urandom_range(1, 8);
                return EXP_W'($urandom) & ((EXP_W'(1) << w) - EXP_W'(1));
            end
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [MOD_W-1:0] m;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at the reset modulus
        send_request('0, '0);
        send_request('0, '1);
        send_request(BASE_W'(5), '0);
        send_request(BASE_W'(MODULUS_RESET), '0);
        send_request(BASE_W'(64'd3 * 64'(MODULUS_RESET)), EXP_W'(7));
        send_request('1, '1);
        send_request(BASE_W'(1), '1);
        send_request(BASE_W'(2), EXP_W'(30));
        send_request(BASE_W'(MODULUS_RESET - 31'd1), EXP_W'(2));
        send_request(BASE_W'(64'(MODULUS_RESET) + 64'd1), EXP_W'(12345));
        send_request(BASE_W'(1) << (BASE_W - 1), EXP_W'(1));
        send_request(BASE_W'(64'd12345678901234), EXP_W'(1) << (EXP_W - 1));
        send_request(BASE_W'(7), EXP_W'(1));
        wait_idle();

        // directed requests with a modulus register below range
        write_modulus(31'd0);
        send_request(BASE_W'(3), EXP_W'(5));
        send_request(BASE_W'(2), '0);
        wait_idle();
        write_modulus(31'd1);
        send_request(BASE_W'(9), EXP_W'(4));
        wait_idle();

        // directed requests at the largest modulus
        write_modulus(31'h7FFF_FFFF);
        send_request(BASE_W'(31'h7FFF_FFFE), '1);
        send_request('1, EXP_W'(3));
        wait_idle();

        // random phases, one modulus each, last one with no idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: m = 31'd2;
                1: m = 31'd3;
                2: m = 31'h7FFF_FFFF;
                3: m = 31'd65537;
                4: m = MOD_W'($urandom_range(4, 1000));
                5: m = MOD_W'($urandom) | 31'h4000_0000;
                6: m = 31'd1;
                7: m = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
                8: m = MODULUS_RESET;
                default: m = MOD_W'($urandom);
            endcase
            write_modulus(m);
            no_idle = (p == NUM_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_base(), pick_exponent());
            wait_idle();
        end

        repeat (20) @(posedge clk);
        sb.check_leftover();
        if (sb.error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
